// ----- src/ptt_link_controller_defines.svh -----
// Assertion macros used by the push-to-talk link controller top level.
`ifndef PTT_LINK_CONTROLLER_DEFINES_SVH
`define PTT_LINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ptt_pkg.sv -----
// Types, codes and reset values for the push-to-talk link controller.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_W         = 16;
    localparam int ELAPSED_W     = 32;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 48;

    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_PRESS   = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_MSG     = 3'd3;
    localparam logic [2:0] ACT_AUDIO   = 3'd4;

    localparam logic [2:0] CTL_TX_ON  = 3'd0;
    localparam logic [2:0] CTL_TX_OFF = 3'd1;
    localparam logic [2:0] CTL_PING   = 3'd2;
    localparam logic [2:0] CTL_PONG   = 3'd3;

    localparam logic [1:0] SEND_TX_ON  = 2'd0;
    localparam logic [1:0] SEND_TX_OFF = 2'd1;
    localparam logic [1:0] SEND_PING   = 2'd2;
    localparam logic [1:0] SEND_PONG   = 2'd3;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_TX     = 2'd1;
    localparam logic [1:0] MODE_RX     = 2'd2;
    localparam logic [1:0] MODE_DUPLEX = 2'd3;

    localparam logic [2:0] REG_REMOTE_PRESENT = 3'd0;
    localparam logic [2:0] REG_RT_TIMEOUT     = 3'd1;
    localparam logic [2:0] REG_PING_PERIOD    = 3'd2;
    localparam logic [2:0] REG_PEER_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_FLASH_PERIOD   = 3'd4;
    localparam logic [2:0] REG_FLASH_LENGTH   = 3'd5;
    localparam logic [2:0] REG_TALK_HALF      = 3'd6;
    localparam logic [2:0] REG_LISTEN_HALF    = 3'd7;

    localparam logic [CFG_W-1:0] RST_RT_TIMEOUT   = 16'd500;
    localparam logic [CFG_W-1:0] RST_PING_PERIOD  = 16'd5000;
    localparam logic [CFG_W-1:0] RST_PEER_TIMEOUT = 16'd15000;
    localparam logic [CFG_W-1:0] RST_FLASH_PERIOD = 16'd3000;
    localparam logic [CFG_W-1:0] RST_FLASH_LENGTH = 16'd200;
    localparam logic [CFG_W-1:0] RST_TALK_HALF    = 16'd150;
    localparam logic [CFG_W-1:0] RST_LISTEN_HALF  = 16'd400;

    typedef struct packed {
        logic             remote_present;
        logic [CFG_W-1:0] rt_timeout;
        logic [CFG_W-1:0] ping_period;
        logic [CFG_W-1:0] peer_timeout;
        logic [CFG_W-1:0] flash_period;
        logic [CFG_W-1:0] flash_length;
        logic [CFG_W-1:0] talk_half;
        logic [CFG_W-1:0] listen_half;
    } cfg_t;

    // Field order matches the high-to-low packing of m_tdata.
    typedef struct packed {
        logic [ELAPSED_W-1:0] talk_elapsed;
        logic                 transmit_enable;
        logic                 play_enable;
        logic                 peer_up;
        logic                 led_lit;
        logic [1:0]           link_mode;
        logic [1:0]           send_kind;
        logic                 send_valid;
    } result_t;

endpackage

// ----- src/ptt_cfg_regs.sv -----
// Configuration register bank of the push-to-talk link controller.
`timescale 1ns / 1ps

module ptt_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0] cfg_wdata,
    output ptt_pkg::cfg_t             cfg
);

    ptt_pkg::cfg_t cfg_reg;
    ptt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ptt_pkg::REG_REMOTE_PRESENT: cfg_next.remote_present = cfg_wdata[0];
                ptt_pkg::REG_RT_TIMEOUT:     cfg_next.rt_timeout     = cfg_wdata;
                ptt_pkg::REG_PING_PERIOD:    cfg_next.ping_period    = cfg_wdata;
                ptt_pkg::REG_PEER_TIMEOUT:   cfg_next.peer_timeout   = cfg_wdata;
                ptt_pkg::REG_FLASH_PERIOD:   cfg_next.flash_period   = cfg_wdata;
                ptt_pkg::REG_FLASH_LENGTH:   cfg_next.flash_length   = cfg_wdata;
                ptt_pkg::REG_TALK_HALF:      cfg_next.talk_half      = cfg_wdata;
                ptt_pkg::REG_LISTEN_HALF:    cfg_next.listen_half    = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.remote_present <= 1'b1;
            cfg_reg.rt_timeout     <= ptt_pkg::RST_RT_TIMEOUT;
            cfg_reg.ping_period    <= ptt_pkg::RST_PING_PERIOD;
            cfg_reg.peer_timeout   <= ptt_pkg::RST_PEER_TIMEOUT;
            cfg_reg.flash_period   <= ptt_pkg::RST_FLASH_PERIOD;
            cfg_reg.flash_length   <= ptt_pkg::RST_FLASH_LENGTH;
            cfg_reg.talk_half      <= ptt_pkg::RST_TALK_HALF;
            cfg_reg.listen_half    <= ptt_pkg::RST_LISTEN_HALF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/ptt_core.sv -----
// Input register, link state and per-item event logic of the link controller.
`timescale 1ns / 1ps

module ptt_core #(
    parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ptt_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       in_action,
    input  logic [2:0]       in_msg_kind,
    input  logic             out_ready,
    output logic             res_valid,
    output ptt_pkg::result_t res
);

    localparam int TB  = TIME_BITS;
    localparam int PAD = TB - ptt_pkg::CFG_W;

    // input register
    logic       in_vld_reg;
    logic [2:0] act_reg;
    logic [2:0] kind_reg;
    logic       adv;

    // link state
    logic          held_reg,   held_next;
    logic          rt_reg,     rt_next;
    logic          peer_reg,   peer_next;
    logic          led_reg,    led_next;
    logic [TB-1:0] clock_reg,  clock_next;
    logic [TB-1:0] seen_reg,   seen_next;
    logic [TB-1:0] ping_reg,   ping_next;
    logic [TB-1:0] contact_reg, contact_next;
    logic [TB-1:0] start_reg,  start_next;
    logic [TB-1:0] blink_reg,  blink_next;

    logic          send;
    logic [1:0]    send_kind;
    logic [TB-1:0] tick_clock;
    logic [TB-1:0] d_blink;
    logic [TB-1:0] d_seen;
    logic [TB-1:0] d_ping;
    logic [TB-1:0] d_contact;
    logic [TB-1:0] elapsed;
    logic [TB+ptt_pkg::ELAPSED_W-1:0] elapsed_ext;
    logic [1:0]    mode_old;

    assign adv      = in_vld_reg && out_ready;
    assign in_ready = !in_vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            act_reg  <= in_action;
            kind_reg <= in_msg_kind;
        end
    end

    assign tick_clock = clock_reg + TB'(1);
    assign d_blink    = tick_clock - blink_reg;
    assign d_seen     = tick_clock - seen_reg;
    assign d_ping     = tick_clock - ping_reg;
    assign d_contact  = tick_clock - contact_reg;
    assign mode_old   = {rt_reg, held_reg};

    always_comb begin
        held_next    = held_reg;
        rt_next      = rt_reg;
        peer_next    = peer_reg;
        led_next     = led_reg;
        clock_next   = clock_reg;
        seen_next    = seen_reg;
        ping_next    = ping_reg;
        contact_next = contact_reg;
        start_next   = start_reg;
        blink_next   = blink_reg;
        send         = 1'b0;
        send_kind    = ptt_pkg::SEND_TX_ON;

        case (act_reg)
            ptt_pkg::ACT_TICK: begin
                clock_next = tick_clock;
                case (mode_old)
                    ptt_pkg::MODE_IDLE: begin
                        if (peer_reg) begin
                            if (!led_reg && d_blink > {{PAD{1'b0}}, cfg.flash_period}) begin
                                blink_next = tick_clock;
                                led_next   = 1'b1;
                            end else if (led_reg &&
                                         d_blink > {{PAD{1'b0}}, cfg.flash_length}) begin
                                led_next = 1'b0;
                            end
                        end else begin
                            led_next = 1'b0;
                        end
                    end
                    ptt_pkg::MODE_TX: begin
                        if (d_blink > {{PAD{1'b0}}, cfg.talk_half}) begin
                            blink_next = tick_clock;
                            led_next   = !led_reg;
                        end
                    end
                    ptt_pkg::MODE_RX: begin
                        if (d_blink > {{PAD{1'b0}}, cfg.listen_half}) begin
                            blink_next = tick_clock;
                            led_next   = !led_reg;
                        end
                    end
                    default: led_next = 1'b1;
                endcase
                if (rt_reg && d_seen > {{PAD{1'b0}}, cfg.rt_timeout}) begin
                    rt_next = 1'b0;
                end
                if (cfg.remote_present && d_ping > {{PAD{1'b0}}, cfg.ping_period}) begin
                    ping_next = tick_clock;
                    send      = 1'b1;
                    send_kind = ptt_pkg::SEND_PING;
                end
                if (peer_reg && d_contact > {{PAD{1'b0}}, cfg.peer_timeout}) begin
                    peer_next = 1'b0;
                end
            end
            ptt_pkg::ACT_PRESS: begin
                if (cfg.remote_present && !held_reg) begin
                    held_next  = 1'b1;
                    start_next = clock_reg;
                    send       = 1'b1;
                    send_kind  = ptt_pkg::SEND_TX_ON;
                end
            end
            ptt_pkg::ACT_RELEASE: begin
                if (held_reg) begin
                    held_next = 1'b0;
                    send      = cfg.remote_present;
                    send_kind = cfg.remote_present ? ptt_pkg::SEND_TX_OFF : ptt_pkg::SEND_TX_ON;
                end
            end
            ptt_pkg::ACT_MSG: begin
                case (kind_reg)
                    ptt_pkg::CTL_TX_ON: begin
                        rt_next      = 1'b1;
                        seen_next    = clock_reg;
                        peer_next    = 1'b1;
                        contact_next = clock_reg;
                    end
                    ptt_pkg::CTL_TX_OFF: rt_next = 1'b0;
                    ptt_pkg::CTL_PING: begin
                        peer_next    = 1'b1;
                        contact_next = clock_reg;
                        send         = cfg.remote_present;
                        send_kind    = cfg.remote_present ? ptt_pkg::SEND_PONG
                                                          : ptt_pkg::SEND_TX_ON;
                    end
                    ptt_pkg::CTL_PONG: begin
                        peer_next    = 1'b1;
                        contact_next = clock_reg;
                    end
                    default: ;
                endcase
            end
            ptt_pkg::ACT_AUDIO: begin
                if (cfg.remote_present) begin
                    seen_next = clock_reg;
                    rt_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 1'b0;
            rt_reg      <= 1'b0;
            peer_reg    <= 1'b0;
            led_reg     <= 1'b0;
            clock_reg   <= '0;
            seen_reg    <= '0;
            ping_reg    <= '0;
            contact_reg <= '0;
            start_reg   <= '0;
            blink_reg   <= '0;
        end else if (adv) begin
            held_reg    <= held_next;
            rt_reg      <= rt_next;
            peer_reg    <= peer_next;
            led_reg     <= led_next;
            clock_reg   <= clock_next;
            seen_reg    <= seen_next;
            ping_reg    <= ping_next;
            contact_reg <= contact_next;
            start_reg   <= start_next;
            blink_reg   <= blink_next;
        end
    end

    assign elapsed     = clock_next - start_next;
    assign elapsed_ext = {{ptt_pkg::ELAPSED_W{1'b0}}, elapsed};

    always_comb begin
        res.send_valid      = send;
        res.send_kind       = send_kind;
        res.link_mode       = {rt_next, held_next};
        res.led_lit         = led_next;
        res.peer_up         = peer_next;
        res.play_enable     = rt_next;
        res.transmit_enable = held_next && cfg.remote_present;
        res.talk_elapsed    = held_next ? elapsed_ext[ptt_pkg::ELAPSED_W-1:0]
                                        : '0;
    end

    assign res_valid = in_vld_reg;

endmodule

// ----- src/ptt_out_reg.sv -----
// Result register of the link controller output channel.
`timescale 1ns / 1ps

module ptt_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  ptt_pkg::result_t res,
    output logic             res_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ptt_pkg::result_t m_res
);

    logic             vld_reg;
    ptt_pkg::result_t data_reg;

    assign res_ready = !vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (res_ready) begin
            vld_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_res    = data_reg;

endmodule

// ----- src/ptt_link_controller.sv -----
// Top level of the push-to-talk link controller.
`timescale 1ns / 1ps
`include "ptt_link_controller_defines.svh"

// Usage:
// Events enter on the s_ stream, one item each: a 1 ms tick, a button press
// or release, a decoded peer control message, or a peer audio header.
// Every item gives exactly one result item on the m_ stream carrying the
// control message to send (if any), the link mode, LED level, peer status,
// playback and transmit enables and the time the button has been held.
// Timer limits and the remote-present flag are written through the cfg_
// port; the user must do so only while no item is in flight, as the block
// does not enforce it. An item is held in the input register while the
// event logic updates the link state and loads the result register, which
// drives m_. One item per cycle is sustained while m_ does not stall; the
// rate is set by the single state update per item in the event stage.
// A stalled m_ side holds the result register; the input register then keeps
// its item and s_tready drops only when both are full.
// Reset clears all flags, timestamps and the millisecond clock and restores
// the register defaults.
module ptt_link_controller #(
    parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] action, [5:3] msg_kind, [7:6] zero
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] send_valid, [2:1] send_kind, [4:3] link_mode, [5] led_lit, [6] peer_up,
    // [7] play_enable, [8] transmit_enable, [40:9] talk_elapsed, [47:41] zero
    output logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int RES_W = $bits(ptt_pkg::result_t);

    ptt_pkg::cfg_t    cfg;
    ptt_pkg::result_t res;
    ptt_pkg::result_t m_res;
    logic             res_valid;
    logic             res_ready;

    ptt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tdata[2:0]),
        .in_msg_kind (s_tdata[5:3]),
        .out_ready   (res_ready),
        .res_valid   (res_valid),
        .res         (res)
    );

    ptt_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {{(ptt_pkg::M_TDATA_W-RES_W){1'b0}}, m_res};

    `PTT_ASSERT_NOW(a_play_mode, aclk, aresetn, m_tvalid,
        m_res.play_enable == m_res.link_mode[1], "play_enable disagrees with link mode")
    `PTT_ASSERT_NOW(a_tx_mode, aclk, aresetn, m_tvalid && m_res.transmit_enable,
        m_res.link_mode[0], "transmit enabled without button held")
    `PTT_ASSERT_NOW(a_no_kind, aclk, aresetn, m_tvalid && !m_res.send_valid,
        m_res.send_kind == ptt_pkg::SEND_TX_ON, "send_kind set without a message")
    `PTT_ASSERT_NEXT(a_hold_item, aclk, aresetn, res_valid && !res_ready,
        res_valid, "pending item dropped while output stalled")
    `PTT_ASSERT_NOW(a_elapsed_idle, aclk, aresetn, m_tvalid && !m_res.link_mode[0],
        m_res.talk_elapsed == '0, "talk time reported with button released")

endmodule

// ----- tb/sv/ptt_link_checker.sv -----
// Checker for the push-to-talk link controller: predicts and compares every result item.
`timescale 1ns / 1ps

module ptt_link_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [2:0] action, [5:3] msg_kind, [7:6] zero
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] send_valid, [2:1] send_kind, [4:3] link_mode, [5] led_lit, [6] peer_up,
    // [7] play_enable, [8] transmit_enable, [40:9] talk_elapsed, [47:41] zero
    input  logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            error_count,
    output int                            outstanding
);

    localparam int TW    = ptt_pkg::TIME_BITS_DEF;
    localparam int RES_W = $bits(ptt_pkg::result_t);

    ptt_pkg::cfg_t cfg;
    logic          held;
    logic          rtalk;
    logic          online;
    logic          led;
    logic [TW-1:0] now_ms;
    logic [TW-1:0] seen_at;
    logic [TW-1:0] ping_at;
    logic [TW-1:0] contact_at;
    logic [TW-1:0] talk_at;
    logic [TW-1:0] blink_at;

    ptt_pkg::result_t predicted_results[$];
    int               result_no = 0;

    function automatic logic [TW-1:0] since_ms(input logic [TW-1:0] stamp);
        return now_ms - stamp;
    endfunction

    function automatic ptt_pkg::result_t advance_link(input logic [2:0] act,
                                                      input logic [2:0] kind);
        ptt_pkg::result_t r;
        logic             send;
        logic [1:0]       sk;
        logic [TW-1:0]    d;
        send = 1'b0;
        sk   = '0;
        case (act)
            ptt_pkg::ACT_TICK: begin
                now_ms = now_ms + 1'b1;
                d = since_ms(blink_at);
                case ({rtalk, held})
                    ptt_pkg::MODE_IDLE: begin
                        if (!online) begin
                            led = 1'b0;
                        end else if (!led && d > cfg.flash_period) begin
                            blink_at = now_ms;
                            led = 1'b1;
                        end else if (led && d > cfg.flash_length) begin
                            led = 1'b0;
                        end
                    end
                    ptt_pkg::MODE_TX: begin
                        if (d > cfg.talk_half) begin
                            blink_at = now_ms;
                            led = !led;
                        end
                    end
                    ptt_pkg::MODE_RX: begin
                        if (d > cfg.listen_half) begin
                            blink_at = now_ms;
                            led = !led;
                        end
                    end
                    default: led = 1'b1;
                endcase
                if (rtalk && since_ms(seen_at) > cfg.rt_timeout)
                    rtalk = 1'b0;
                if (cfg.remote_present && since_ms(ping_at) > cfg.ping_period) begin
                    ping_at = now_ms;
                    send = 1'b1;
                    sk = ptt_pkg::SEND_PING;
                end
                if (online && since_ms(contact_at) > cfg.peer_timeout)
                    online = 1'b0;
            end
            ptt_pkg::ACT_PRESS: begin
                if (cfg.remote_present && !held) begin
                    held = 1'b1;
                    talk_at = now_ms;
                    send = 1'b1;
                    sk = ptt_pkg::SEND_TX_ON;
                end
            end
            ptt_pkg::ACT_RELEASE: begin
                if (held) begin
                    held = 1'b0;
                    send = cfg.remote_present;
                    sk = ptt_pkg::SEND_TX_OFF;
                end
            end
            ptt_pkg::ACT_MSG: begin
                case (kind)
                    ptt_pkg::CTL_TX_ON: begin
                        rtalk = 1'b1;
                        seen_at = now_ms;
                        online = 1'b1;
                        contact_at = now_ms;
                    end
                    ptt_pkg::CTL_TX_OFF: rtalk = 1'b0;
                    ptt_pkg::CTL_PING: begin
                        online = 1'b1;
                        contact_at = now_ms;
                        send = cfg.remote_present;
                        sk = ptt_pkg::SEND_PONG;
                    end
                    ptt_pkg::CTL_PONG: begin
                        online = 1'b1;
                        contact_at = now_ms;
                    end
                    default: ;
                endcase
            end
            ptt_pkg::ACT_AUDIO: begin
                if (cfg.remote_present) begin
                    seen_at = now_ms;
                    rtalk = 1'b1;
                end
            end
            default: ;
        endcase
        if (!send)
            sk = '0;
        r.send_valid      = send;
        r.send_kind       = sk;
        r.link_mode       = {rtalk, held};
        r.led_lit         = led;
        r.peer_up         = online;
        r.play_enable     = rtalk;
        r.transmit_enable = held && cfg.remote_present;
        r.talk_elapsed    = held ? since_ms(talk_at) : '0;
        return r;
    endfunction

    task automatic report(input string what, input logic [ptt_pkg::M_TDATA_W-1:0] got,
                          input logic [ptt_pkg::M_TDATA_W-1:0] want);
        error_count++;
        $display("%0t: result %0d: %s got %0h expected %0h",
                 $realtime, result_no, what, got, want);
    endtask

    always @(posedge aclk) begin : watch
        ptt_pkg::result_t want;
        ptt_pkg::result_t got;
        if (!aresetn) begin
            cfg.remote_present = 1'b1;
            cfg.rt_timeout     = ptt_pkg::RST_RT_TIMEOUT;
            cfg.ping_period    = ptt_pkg::RST_PING_PERIOD;
            cfg.peer_timeout   = ptt_pkg::RST_PEER_TIMEOUT;
            cfg.flash_period   = ptt_pkg::RST_FLASH_PERIOD;
            cfg.flash_length   = ptt_pkg::RST_FLASH_LENGTH;
            cfg.talk_half      = ptt_pkg::RST_TALK_HALF;
            cfg.listen_half    = ptt_pkg::RST_LISTEN_HALF;
            held       = 1'b0;
            rtalk      = 1'b0;
            online     = 1'b0;
            led        = 1'b0;
            now_ms     = '0;
            seen_at    = '0;
            ping_at    = '0;
            contact_at = '0;
            talk_at    = '0;
            blink_at   = '0;
            predicted_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ptt_pkg::REG_REMOTE_PRESENT: cfg.remote_present = cfg_wdata[0];
                    ptt_pkg::REG_RT_TIMEOUT:     cfg.rt_timeout     = cfg_wdata;
                    ptt_pkg::REG_PING_PERIOD:    cfg.ping_period    = cfg_wdata;
                    ptt_pkg::REG_PEER_TIMEOUT:   cfg.peer_timeout   = cfg_wdata;
                    ptt_pkg::REG_FLASH_PERIOD:   cfg.flash_period   = cfg_wdata;
                    ptt_pkg::REG_FLASH_LENGTH:   cfg.flash_length   = cfg_wdata;
                    ptt_pkg::REG_TALK_HALF:      cfg.talk_half      = cfg_wdata;
                    ptt_pkg::REG_LISTEN_HALF:    cfg.listen_half    = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(advance_link(s_tdata[2:0], s_tdata[5:3]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[RES_W-1:0];
                if (predicted_results.size() == 0) begin
                    report("unexpected item", m_tdata, '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.send_valid !== want.send_valid)
                        report("send_valid", got.send_valid, want.send_valid);
                    if (got.send_kind !== want.send_kind)
                        report("send_kind", got.send_kind, want.send_kind);
                    if (got.link_mode !== want.link_mode)
                        report("link_mode", got.link_mode, want.link_mode);
                    if (got.led_lit !== want.led_lit)
                        report("led_lit", got.led_lit, want.led_lit);
                    if (got.peer_up !== want.peer_up)
                        report("peer_up", got.peer_up, want.peer_up);
                    if (got.play_enable !== want.play_enable)
                        report("play_enable", got.play_enable, want.play_enable);
                    if (got.transmit_enable !== want.transmit_enable)
                        report("transmit_enable", got.transmit_enable, want.transmit_enable);
                    if (got.talk_elapsed !== want.talk_elapsed)
                        report("talk_elapsed", got.talk_elapsed, want.talk_elapsed);
                    if (m_tdata[ptt_pkg::M_TDATA_W-1:RES_W] !== '0)
                        report("padding", m_tdata[ptt_pkg::M_TDATA_W-1:RES_W], '0);
                end
                result_no++;
            end
        end
        outstanding = predicted_results.size();
    end

endmodule

// ----- tb/sv/ptt_link_controller_tb.sv -----
// Top of the push-to-talk link controller testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module ptt_link_controller_tb;

    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] ACT_FIRST_UNUSED = ptt_pkg::ACT_AUDIO + 3'd1;
    localparam logic [2:0] CTL_FIRST_UNUSED = ptt_pkg::CTL_PONG + 3'd1;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BURSTY} ready_style_t;
    typedef enum logic [1:0] {SET_SMALL, SET_MIXED, SET_ZERO, SET_MAX} set_style_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    // [2:0] action, [5:3] msg_kind, [7:6] zero
    logic [ptt_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    // [0] send_valid, [2:1] send_kind, [4:3] link_mode, [5] led_lit, [6] peer_up,
    // [7] play_enable, [8] transmit_enable, [40:9] talk_elapsed, [47:41] zero
    logic [ptt_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_wr_en = 1'b0;
    logic [2:0]                    cfg_index = '0;
    logic [ptt_pkg::CFG_W-1:0]     cfg_wdata = '0;

    int error_count;
    int outstanding;
    int burst_left = 0;
    int quiet_cycles = 0;

    ready_style_t ready_style = RDY_ALWAYS;
    int           seg_left = 0;
    logic [7:0]   ready_phase = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ptt_link_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ptt_link_checker link_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // result side backpressure, changes style every segment
    always @(posedge aclk) begin
        if (seg_left == 0) begin
            seg_left    <= $urandom_range(16, 200);
            ready_style <= ready_style_t'($urandom_range(0, 3));
        end else begin
            seg_left <= seg_left - 1;
        end
        ready_phase <= ready_phase + 1'b1;
        case (ready_style)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_tready <= (ready_phase[2:0] == 3'd0);
            default:    m_tready <= (ready_phase[3:2] == 2'd0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [2:0] any_kind();
        return 3'($urandom);
    endfunction

    function automatic logic [ptt_pkg::CFG_W-1:0] timer_value(input set_style_t style);
        int roll;
        roll = $urandom_range(0, 9);
        case (style)
            SET_SMALL: return ptt_pkg::CFG_W'($urandom_range(1, 24));
            SET_ZERO:  return '0;
            SET_MAX:   return '1;
            default: begin
                if (roll == 0)
                    return '0;
                else if (roll == 1)
                    return '1;
                else if (roll == 2)
                    return ptt_pkg::CFG_W'($urandom);
                else
                    return ptt_pkg::CFG_W'($urandom_range(1, 60));
            end
        endcase
    endfunction

    task automatic send_event(input logic [2:0] act, input logic [2:0] kind);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ptt_pkg::S_TDATA_W-6){1'b0}}, kind, act};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic pick_event(output logic [2:0] act, output logic [2:0] kind);
        int roll;
        roll = $urandom_range(0, 99);
        kind = any_kind();
        if (roll < 45) begin
            act = ptt_pkg::ACT_TICK;
        end else if (roll < 57) begin
            act = ptt_pkg::ACT_PRESS;
        end else if (roll < 69) begin
            act = ptt_pkg::ACT_RELEASE;
        end else if (roll < 87) begin
            act = ptt_pkg::ACT_MSG;
            if ($urandom_range(0, 5) == 0)
                kind = 3'($urandom_range(int'(CTL_FIRST_UNUSED), 7));
            else
                kind = 3'($urandom_range(int'(ptt_pkg::CTL_TX_ON), int'(ptt_pkg::CTL_PONG)));
        end else if (roll < 97) begin
            act = ptt_pkg::ACT_AUDIO;
        end else begin
            act = 3'($urandom_range(int'(ACT_FIRST_UNUSED), 7));
        end
    endtask

    // drop valid and let every result drain before touching registers
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [ptt_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input ptt_pkg::cfg_t c);
        logic [ptt_pkg::CFG_W-2:0] junk;
        junk = (ptt_pkg::CFG_W-1)'($urandom);
        put_reg(ptt_pkg::REG_REMOTE_PRESENT, {junk, c.remote_present});
        put_reg(ptt_pkg::REG_RT_TIMEOUT,   c.rt_timeout);
        put_reg(ptt_pkg::REG_PING_PERIOD,  c.ping_period);
        put_reg(ptt_pkg::REG_PEER_TIMEOUT, c.peer_timeout);
        put_reg(ptt_pkg::REG_FLASH_PERIOD, c.flash_period);
        put_reg(ptt_pkg::REG_FLASH_LENGTH, c.flash_length);
        put_reg(ptt_pkg::REG_TALK_HALF,    c.talk_half);
        put_reg(ptt_pkg::REG_LISTEN_HALF,  c.listen_half);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        ptt_pkg::cfg_t setting;
        set_style_t    style;
        logic [2:0]    act;
        logic [2:0]    kind;
        int            n_items;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults; press lands at clock zero
        send_event(ptt_pkg::ACT_PRESS, any_kind());
        send_event(ptt_pkg::ACT_TICK, any_kind());
        send_event(ptt_pkg::ACT_PRESS, any_kind());
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_TX_ON);
        send_event(ptt_pkg::ACT_TICK, any_kind());
        send_event(ptt_pkg::ACT_AUDIO, any_kind());
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_TX_OFF);
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_TX_OFF);
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_PING);
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_PONG);
        send_event(ptt_pkg::ACT_RELEASE, any_kind());
        send_event(ptt_pkg::ACT_RELEASE, any_kind());
        send_event(ACT_FIRST_UNUSED, any_kind());
        send_event('1, any_kind());
        send_event(ptt_pkg::ACT_MSG, CTL_FIRST_UNUSED);
        send_event(ptt_pkg::ACT_MSG, '1);
        send_event(ptt_pkg::ACT_PRESS, any_kind());

        // no remote, all timers zero, button still held
        wait_quiet();
        setting = '0;
        apply_settings(setting);
        send_event(ptt_pkg::ACT_TICK, any_kind());
        send_event(ptt_pkg::ACT_RELEASE, any_kind());
        send_event(ptt_pkg::ACT_PRESS, any_kind());
        send_event(ptt_pkg::ACT_AUDIO, any_kind());
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_PING);

        // remote back, timers still zero
        wait_quiet();
        setting.remote_present = 1'b1;
        apply_settings(setting);
        send_event(ptt_pkg::ACT_TICK, any_kind());
        send_event(ptt_pkg::ACT_TICK, any_kind());
        send_event(ptt_pkg::ACT_MSG, ptt_pkg::CTL_TX_ON);
        send_event(ptt_pkg::ACT_TICK, any_kind());

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 6)
                2:       style = SET_ZERO;
                4:       style = SET_MAX;
                default: style = (phase % 2 == 0) ? SET_SMALL : SET_MIXED;
            endcase
            setting.remote_present = ($urandom_range(0, 4) != 0);
            setting.rt_timeout     = timer_value(style);
            setting.ping_period    = timer_value(style);
            setting.peer_timeout   = timer_value(style);
            setting.flash_period   = timer_value(style);
            setting.flash_length   = timer_value(style);
            setting.talk_half      = timer_value(style);
            setting.listen_half    = timer_value(style);
            wait_quiet();
            apply_settings(setting);
            n_items = (style == SET_MAX) ? 40 : 175;
            repeat (n_items) begin
                pick_event(act, kind);
                send_event(act, kind);
                if ($urandom_range(0, 299) == 0)
                    wait_quiet();
            end
        end

        wait_quiet();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
